@@ design/sph_pkg.sv @@
// Shared constants, types and saturation helpers for the SPH half-step integrator.
// No dependencies.
package sph_pkg;

	localparam int COMPONENT_BITS = 21;
	localparam int VEC_W          = 3 * COMPONENT_BITS;
	localparam int NUM_TYPES      = 4;
	localparam int WIDE           = 64;
	localparam int DIV_W          = 32 + COMPONENT_BITS - 1;
	localparam int LANE_LAT       = DIV_W + 4;

	localparam logic [1:0] ACT_INIT  = 2'd0;
	localparam logic [1:0] ACT_FINAL = 2'd1;
	localparam logic [1:0] ACT_COPY  = 2'd2;
	localparam logic [1:0] ACT_ADD   = 2'd3;

	localparam logic [2:0] REG_DTF       = 3'd0;
	localparam logic [2:0] REG_DTV       = 3'd1;
	localparam logic [2:0] REG_GROUP     = 3'd2;
	localparam logic [2:0] REG_ITEM_MASS = 3'd3;
	localparam logic [2:0] REG_MASS_ONE  = 3'd4;

	typedef struct packed {
		logic [15:0]        index;
		logic [1:0]         action;
		logic               active;
		logic               mzero;
		logic signed [31:0] e;
		logic signed [31:0] rho;
		logic               sov;
	} sph_side_t;

	// {overflow, value} clamped to the signed component range
	function automatic logic [COMPONENT_BITS:0] sat_c(input logic signed [WIDE-1:0] x);
		logic signed [WIDE-1:0] cmax;
		logic signed [WIDE-1:0] cmin;
		cmax = (WIDE'(1) <<< (COMPONENT_BITS - 1)) - WIDE'(1);
		cmin = -cmax - WIDE'(1);
		if (x > cmax)
			return {1'b1, cmax[COMPONENT_BITS-1:0]};
		else if (x < cmin)
			return {1'b1, cmin[COMPONENT_BITS-1:0]};
		else
			return {1'b0, x[COMPONENT_BITS-1:0]};
	endfunction

	function automatic logic [32:0] sat_32(input logic signed [WIDE-1:0] x);
		logic signed [WIDE-1:0] cmax;
		logic signed [WIDE-1:0] cmin;
		cmax = (WIDE'(1) <<< 31) - WIDE'(1);
		cmin = -cmax - WIDE'(1);
		if (x > cmax)
			return {1'b1, cmax[31:0]};
		else if (x < cmin)
			return {1'b1, cmin[31:0]};
		else
			return {1'b0, x[31:0]};
	endfunction

endpackage

@@ design/sph_pipe_delay.sv @@
// Enable-gated payload delay line.
// No dependencies.
module sph_pipe_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	logic [WIDTH-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < DEPTH; i++)
				tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[DEPTH-1];
endmodule

@@ design/sph_lane.sv @@
// One vector component: force product, pipelined restoring divide by mass,
// velocity/estimate/position update with saturation. Uses sph_pkg, sph_pipe_delay.
module sph_lane (
	input  logic                                       clk,
	input  logic                                       en,
	input  logic [31:0]                                dtf,
	input  logic [31:0]                                dtv,
	input  logic [31:0]                                mass,
	input  logic [1:0]                                 action,
	input  logic                                       active,
	input  logic signed [sph_pkg::COMPONENT_BITS-1:0] x,
	input  logic signed [sph_pkg::COMPONENT_BITS-1:0] v,
	input  logic signed [sph_pkg::COMPONENT_BITS-1:0] f,
	input  logic signed [sph_pkg::COMPONENT_BITS-1:0] ve,
	output logic [sph_pkg::COMPONENT_BITS-1:0]        x_o,
	output logic [sph_pkg::COMPONENT_BITS-1:0]        v_o,
	output logic [sph_pkg::COMPONENT_BITS-1:0]        ve_o,
	output logic                                       ov_o
);
	localparam int CB = sph_pkg::COMPONENT_BITS;
	localparam int NW = sph_pkg::DIV_W;
	localparam int PW = 33 + CB;
	localparam int QW = NW + 2;
	localparam int W  = sph_pkg::WIDE;
	localparam int SW = 5 + 3 * CB;

	// stage 1: product and magnitude
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] prod_abs;
	logic [NW-1:0]        mag_s1;
	logic [31:0]          mass_s1;
	logic [SW-1:0]        side_s1;

	assign prod     = $signed({1'b0, dtf}) * f;
	assign prod_abs = prod[PW-1] ? -prod : prod;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= prod_abs[NW-1:0];
			mass_s1 <= mass;
			side_s1 <= {prod[PW-1], (mass == 32'd0), active, action, x, v, ve};
		end
	end

	// divider stages: one quotient bit each
	logic [31:0]   rem_sd  [NW];
	logic [NW-1:0] dq_sd   [NW];
	logic [31:0]   mass_sd [NW];

	for (genvar j = 0; j < NW; j++) begin : g_div
		logic [31:0]   r_in;
		logic [NW-1:0] dq_in;
		logic [31:0]   m_in;
		logic [32:0]   t;
		logic          ge;
		logic [32:0]   diff;
		if (j == 0) begin : g_first
			assign r_in  = '0;
			assign dq_in = mag_s1;
			assign m_in  = mass_s1;
		end else begin : g_next
			assign r_in  = rem_sd[j-1];
			assign dq_in = dq_sd[j-1];
			assign m_in  = mass_sd[j-1];
		end
		assign t    = {r_in, dq_in[NW-1]};
		assign ge   = t >= {1'b0, m_in};
		assign diff = t - {1'b0, m_in};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[j]  <= ge ? diff[31:0] : t[31:0];
				dq_sd[j]   <= {dq_in[NW-2:0], ge};
				mass_sd[j] <= m_in;
			end
		end
	end

	logic [SW-1:0] side_d;
	sph_pipe_delay #(.WIDTH(SW), .DEPTH(NW)) u_side (
		.clk(clk), .en(en), .d(side_s1), .q(side_d)
	);

	logic                 neg_d, mz_d, act_d;
	logic [1:0]           action_d;
	logic signed [CB-1:0] x_d, v_d, ve_d;
	assign {neg_d, mz_d, act_d, action_d, x_d, v_d, ve_d} = side_d;

	// stage 2: rounding and velocity terms
	logic signed [QW-1:0] q_sg, qh, qt, hs, ts;
	logic [CB:0]          sh, st, sa;

	assign q_sg = mz_d ? '0 : (neg_d ? -$signed({2'b0, dq_sd[NW-1]})
	                                 :  $signed({2'b0, dq_sd[NW-1]}));
	assign qh = q_sg + QW'(128);
	assign qt = q_sg + QW'(64);
	assign hs = qh >>> 8;
	assign ts = qt >>> 7;
	assign sh = sph_pkg::sat_c(W'(v_d) + W'(hs));
	assign st = sph_pkg::sat_c(W'(v_d) + W'(ts));
	assign sa = sph_pkg::sat_c(W'(v_d) + W'(ve_d));

	logic signed [CB-1:0] vh_s2, vt_s2, va_s2, x_s2, v_s2, ve_s2;
	logic                 ovh_s2, ovt_s2, ova_s2, act_s2;
	logic [1:0]           action_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			vh_s2     <= sh[CB-1:0];
			vt_s2     <= st[CB-1:0];
			va_s2     <= sa[CB-1:0];
			ovh_s2    <= sh[CB];
			ovt_s2    <= st[CB];
			ova_s2    <= sa[CB];
			x_s2      <= x_d;
			v_s2      <= v_d;
			ve_s2     <= ve_d;
			act_s2    <= act_d;
			action_s2 <= action_d;
		end
	end

	// stage 3: position product
	logic signed [PW-1:0] pv_s3;
	logic signed [CB-1:0] vh_s3, vt_s3, va_s3, x_s3, v_s3, ve_s3;
	logic                 ovh_s3, ovt_s3, ova_s3, act_s3;
	logic [1:0]           action_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pv_s3     <= $signed({1'b0, dtv}) * vh_s2;
			vh_s3     <= vh_s2;
			vt_s3     <= vt_s2;
			va_s3     <= va_s2;
			ovh_s3    <= ovh_s2;
			ovt_s3    <= ovt_s2;
			ova_s3    <= ova_s2;
			x_s3      <= x_s2;
			v_s3      <= v_s2;
			ve_s3     <= ve_s2;
			act_s3    <= act_s2;
			action_s3 <= action_s2;
		end
	end

	// stage 4: position update and action select
	logic signed [PW-1:0] pr;
	logic [CB:0]          sx;
	assign pr = (pv_s3 + (PW'(1) <<< 23)) >>> 24;
	assign sx = sph_pkg::sat_c(W'(x_s3) + W'(pr));

	always_ff @(posedge clk) begin
		if (en) begin
			x_o  <= x_s3;
			v_o  <= v_s3;
			ve_o <= ve_s3;
			ov_o <= 1'b0;
			if (act_s3) begin
				case (action_s3)
					sph_pkg::ACT_INIT: begin
						x_o  <= sx[CB-1:0];
						v_o  <= vh_s3;
						ve_o <= vt_s3;
						ov_o <= sx[CB] | ovh_s3 | ovt_s3;
					end
					sph_pkg::ACT_FINAL: begin
						v_o  <= vh_s3;
						ov_o <= ovh_s3;
					end
					sph_pkg::ACT_COPY: begin
						ve_o <= v_s3;
					end
					default: begin
						ve_o <= va_s3;
						ov_o <= ova_s3;
					end
				endcase
			end
		end
	end
endmodule

@@ design/sph_half_step_integrator_top.sv @@
// Top level of the SPH half-step integrator: config registers, scalar path,
// three component lanes, merge and output skid. Uses sph_pkg, sph_lane, sph_pipe_delay.
//
//  channel | signals                              | beat
//  in      | in_valid, in_ready, particle fields  | one particle
//  out     | out_valid, out_ready, result fields  | one updated particle
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | one register write
//
// One particle per cycle sustained while not frozen; the pipeline depth is set by the
// one-bit-per-stage mass divider in each lane. Reset clears valid bits and sets the
// config registers to defaults; no clearing pass. An output register plus one skid entry
// decouple the sides: the pipeline freezes only when both hold results.
module sph_half_step_integrator_top #(
	parameter int NUM_TYPES = sph_pkg::NUM_TYPES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 action,
	input  logic [15:0]                particle_index,
	input  logic [31:0]                group_mask,
	input  logic [2:0]                 atom_type,
	input  logic [31:0]                atom_mass,
	input  logic [sph_pkg::VEC_W-1:0] position_xyz,
	input  logic [sph_pkg::VEC_W-1:0] velocity_xyz,
	input  logic [sph_pkg::VEC_W-1:0] force_xyz,
	input  logic [sph_pkg::VEC_W-1:0] vest_xyz,
	input  logic [63:0]                energy_density,
	input  logic [63:0]                energy_density_rates,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [15:0]                result_index,
	output logic [sph_pkg::VEC_W-1:0] new_position_xyz,
	output logic [sph_pkg::VEC_W-1:0] new_velocity_xyz,
	output logic [sph_pkg::VEC_W-1:0] new_vest_xyz,
	output logic [63:0]                new_energy_density,
	output logic                       overflow,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [2:0]                 cfg_index,
	input  logic [31:0]                cfg_data
);
	localparam int CB  = sph_pkg::COMPONENT_BITS;
	localparam int L   = sph_pkg::LANE_LAT;
	localparam int VW  = sph_pkg::VEC_W;
	localparam int SPW = 65;
	localparam int RW  = 16 + 3 * VW + 64 + 1;

	// configuration
	logic [31:0] dtf_q, dtv_q, group_q;
	logic        item_mass_q;
	logic [31:0] mass_q [NUM_TYPES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dtf_q       <= '0;
			dtv_q       <= '0;
			group_q     <= 32'd1;
			item_mass_q <= 1'b0;
			for (int t = 0; t < NUM_TYPES; t++)
				mass_q[t] <= 32'd65536;
		end else if (cfg_valid) begin
			case (cfg_index)
				sph_pkg::REG_DTF:       dtf_q       <= cfg_data;
				sph_pkg::REG_DTV:       dtv_q       <= cfg_data;
				sph_pkg::REG_GROUP:     group_q     <= cfg_data;
				sph_pkg::REG_ITEM_MASS: item_mass_q <= cfg_data[0];
				default: begin
					for (int t = 0; t < NUM_TYPES; t++)
						if (cfg_index == sph_pkg::REG_MASS_ONE + 3'(t))
							mass_q[t] <= cfg_data;
				end
			endcase
		end
	end

	// pipeline control
	logic         en, take, push;
	logic [L-1:0] vld_q;
	logic         out_valid_q, skid_valid_q;
	logic [RW-1:0] out_q, skid_q, res;

	assign en       = !skid_valid_q;
	assign in_ready = en;
	assign take     = out_valid_q && out_ready;
	assign push     = en && vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[L-2:0], in_valid};
	end

	// mass select and group match
	logic [31:0] mass_sel;
	logic        active;

	always_comb begin
		mass_sel = '0;
		if (item_mass_q)
			mass_sel = atom_mass;
		else
			for (int t = 0; t < NUM_TYPES; t++)
				if (atom_type == 3'(t + 1))
					mass_sel = mass_q[t];
	end

	assign active = |(group_mask & group_q);

	// scalar path
	logic [15:0]           index_s1, index_s2;
	logic [1:0]            action_s1, action_s2;
	logic                  active_s1, active_s2, mz_s1, mz_s2;
	logic signed [31:0]    e_s1, rho_s1;
	logic signed [SPW-1:0] pe_s1, prho_s1;
	logic signed [SPW-1:0] re, rr;
	logic [32:0]           se, sr;
	logic                  upd_s1;
	sph_pkg::sph_side_t    side_s2, side_l;

	always_ff @(posedge clk) begin
		if (en) begin
			index_s1  <= particle_index;
			action_s1 <= action;
			active_s1 <= active;
			mz_s1     <= (mass_sel == 32'd0);
			e_s1      <= energy_density[63:32];
			rho_s1    <= energy_density[31:0];
			pe_s1     <= $signed({1'b0, dtf_q}) * $signed(energy_density_rates[63:32]);
			prho_s1   <= $signed({1'b0, dtf_q}) * $signed(energy_density_rates[31:0]);
		end
	end

	assign upd_s1 = active_s1 &&
		(action_s1 == sph_pkg::ACT_INIT || action_s1 == sph_pkg::ACT_FINAL);
	assign re = (pe_s1 + (SPW'(1) <<< 23)) >>> 24;
	assign rr = (prho_s1 + (SPW'(1) <<< 23)) >>> 24;
	assign se = sph_pkg::sat_32(sph_pkg::WIDE'(e_s1) + re[sph_pkg::WIDE-1:0]);
	assign sr = sph_pkg::sat_32(sph_pkg::WIDE'(rho_s1) + rr[sph_pkg::WIDE-1:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.index  <= index_s1;
			side_s2.action <= action_s1;
			side_s2.active <= active_s1;
			side_s2.mzero  <= mz_s1;
			side_s2.e      <= upd_s1 ? se[31:0] : e_s1;
			side_s2.rho    <= upd_s1 ? sr[31:0] : rho_s1;
			side_s2.sov    <= upd_s1 && (se[32] || sr[32]);
		end
	end

	assign index_s2  = side_s2.index;
	assign action_s2 = side_s2.action;
	assign active_s2 = side_s2.active;
	assign mz_s2     = side_s2.mzero;

	sph_pipe_delay #(.WIDTH($bits(sph_pkg::sph_side_t)), .DEPTH(L - 2)) u_side (
		.clk(clk), .en(en),
		.d({index_s2, action_s2, active_s2, mz_s2, side_s2.e, side_s2.rho, side_s2.sov}),
		.q(side_l)
	);

	// lanes
	logic [CB-1:0] lx [3];
	logic [CB-1:0] lv [3];
	logic [CB-1:0] lve [3];
	logic [2:0]    lov;

	for (genvar k = 0; k < 3; k++) begin : g_lane
		sph_lane u_lane (
			.clk(clk), .en(en), .dtf(dtf_q), .dtv(dtv_q), .mass(mass_sel),
			.action(action), .active(active),
			.x($signed(position_xyz[(3-k)*CB-1 -: CB])),
			.v($signed(velocity_xyz[(3-k)*CB-1 -: CB])),
			.f($signed(force_xyz[(3-k)*CB-1 -: CB])),
			.ve($signed(vest_xyz[(3-k)*CB-1 -: CB])),
			.x_o(lx[k]), .v_o(lv[k]), .ve_o(lve[k]), .ov_o(lov[k])
		);
	end

	// merge
	logic mz_ov;
	assign mz_ov = side_l.active && side_l.mzero &&
		(side_l.action == sph_pkg::ACT_INIT || side_l.action == sph_pkg::ACT_FINAL);
	assign res = {side_l.index,
	              lx[0], lx[1], lx[2],
	              lv[0], lv[1], lv[2],
	              lve[0], lve[1], lve[2],
	              side_l.e, side_l.rho,
	              side_l.sov | (|lov) | mz_ov};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign {result_index, new_position_xyz, new_velocity_xyz, new_vest_xyz,
	        new_energy_density, overflow} = out_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q) else $error("skid holds beat without output");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> $stable(vld_q)) else $error("pipeline moved while skid full");
	a_tail_held: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[L-1] && !en |=> vld_q[L-1]) else $error("stalled result lost");
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0]) else $error("accepted beat not in pipeline");
endmodule

@@ sim/sph_half_step_integrator_top_tb.sv @@
// Testbench for sph_half_step_integrator_top: directed and random particles under several
// register settings, checked against an in-bench fixed-point integrator model.
// Depends on sph_pkg and the integrator RTL only.
module sph_half_step_integrator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = sph_pkg::COMPONENT_BITS;
	localparam int VW = sph_pkg::VEC_W;
	localparam int DRAIN = 80;
	localparam int WATCHDOG = 5000;

	typedef struct {
		logic [1:0]    action;
		logic [15:0]   index;
		logic [31:0]   mask;
		logic [2:0]    atype;
		logic [31:0]   mass;
		logic [VW-1:0] pos;
		logic [VW-1:0] vel;
		logic [VW-1:0] frc;
		logic [VW-1:0] vest;
		logic [63:0]   ed;
		logic [63:0]   rates;
	} particle_t;

	typedef struct {
		logic [15:0]   index;
		logic [VW-1:0] pos;
		logic [VW-1:0] vel;
		logic [VW-1:0] vest;
		logic [63:0]   ed;
		logic          ov;
	} update_t;

	class verlet_scoreboard;
		bit [31:0] dtf;
		bit [31:0] dtv;
		bit [31:0] group;
		bit        item_mass;
		bit [31:0] type_mass[4];
		update_t   expected_q[$];
		int        errors;

		function new();
			dtf = 0;
			dtv = 0;
			group = 1;
			item_mass = 0;
			foreach (type_mass[k])
				type_mass[k] = 32'd65536;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				sph_pkg::REG_DTF:       dtf = data;
				sph_pkg::REG_DTV:       dtv = data;
				sph_pkg::REG_GROUP:     group = data;
				sph_pkg::REG_ITEM_MASS: item_mass = data[0];
				default:                type_mass[idx - sph_pkg::REG_MASS_ONE] = data;
			endcase
		endfunction

		function longint comp(logic [VW-1:0] vec, int k);
			logic signed [CB-1:0] c;
			c = vec[(2-k)*CB +: CB];
			return longint'(c);
		endfunction

		function longint clamp(longint x, int bits, inout bit ov);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (bits - 1)) - 1;
			lo = -hi - 1;
			if (x > hi) begin
				ov = 1;
				return hi;
			end
			if (x < lo) begin
				ov = 1;
				return lo;
			end
			return x;
		endfunction

		function longint scalar_step(longint s, longint rate, inout bit ov);
			longint p;
			p = longint'(dtf) * rate;
			return clamp(s + ((p + (longint'(1) <<< 23)) >>> 24), 32, ov);
		endfunction

		function update_t advance(particle_t it);
			update_t r;
			longint x[3], v[3], f[3], ve[3], half[3], twice[3];
			longint e, rho, de, drho, q, p, m;
			logic signed [31:0] w;
			bit ov;
			ov = 0;
			for (int k = 0; k < 3; k++) begin
				x[k] = comp(it.pos, k);
				v[k] = comp(it.vel, k);
				f[k] = comp(it.frc, k);
				ve[k] = comp(it.vest, k);
				half[k] = 0;
				twice[k] = 0;
			end
			w = it.ed[63:32];    e = w;
			w = it.ed[31:0];     rho = w;
			w = it.rates[63:32]; de = w;
			w = it.rates[31:0];  drho = w;
			if ((it.mask & group) != 0) begin
				if (it.action == sph_pkg::ACT_INIT || it.action == sph_pkg::ACT_FINAL) begin
					if (item_mass)
						m = it.mass;
					else if (it.atype >= 1 && it.atype <= sph_pkg::NUM_TYPES)
						m = type_mass[it.atype - 1];
					else
						m = 0;
					if (m == 0)
						ov = 1;
					else begin
						for (int k = 0; k < 3; k++) begin
							q = (longint'(dtf) * f[k]) / m;
							half[k] = (q + 128) >>> 8;
							twice[k] = (q + 64) >>> 7;
						end
					end
					e = scalar_step(e, de, ov);
					rho = scalar_step(rho, drho, ov);
					for (int k = 0; k < 3; k++) begin
						if (it.action == sph_pkg::ACT_INIT)
							ve[k] = clamp(v[k] + twice[k], CB, ov);
						v[k] = clamp(v[k] + half[k], CB, ov);
						if (it.action == sph_pkg::ACT_INIT) begin
							p = longint'(dtv) * v[k];
							x[k] = clamp(x[k] + ((p + (longint'(1) <<< 23)) >>> 24), CB, ov);
						end
					end
				end else if (it.action == sph_pkg::ACT_COPY) begin
					for (int k = 0; k < 3; k++)
						ve[k] = v[k];
				end else begin
					for (int k = 0; k < 3; k++)
						ve[k] = clamp(ve[k] + v[k], CB, ov);
				end
			end
			r.index = it.index;
			for (int k = 0; k < 3; k++) begin
				r.pos[(2-k)*CB +: CB] = x[k][CB-1:0];
				r.vel[(2-k)*CB +: CB] = v[k][CB-1:0];
				r.vest[(2-k)*CB +: CB] = ve[k][CB-1:0];
			end
			r.ed = {e[31:0], rho[31:0]};
			r.ov = ov;
			return r;
		endfunction

		function void note_particle(particle_t it);
			expected_q.push_back(advance(it));
		endfunction

		function void check_particle(update_t got);
			update_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result index %h", $time, got.index);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.index !== exp_r.index) begin
				$display("%0t: index exp %h got %h", $time, exp_r.index, got.index);
				errors++;
			end
			if (got.pos !== exp_r.pos) begin
				$display("%0t: position exp %h got %h", $time, exp_r.pos, got.pos);
				errors++;
			end
			if (got.vel !== exp_r.vel) begin
				$display("%0t: velocity exp %h got %h", $time, exp_r.vel, got.vel);
				errors++;
			end
			if (got.vest !== exp_r.vest) begin
				$display("%0t: vest exp %h got %h", $time, exp_r.vest, got.vest);
				errors++;
			end
			if (got.ed !== exp_r.ed) begin
				$display("%0t: energy/density exp %h got %h", $time, exp_r.ed, got.ed);
				errors++;
			end
			if (got.ov !== exp_r.ov) begin
				$display("%0t: overflow exp %b got %b", $time, exp_r.ov, got.ov);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] action = 0;
	logic [15:0] particle_index = 0;
	logic [31:0] group_mask = 0;
	logic [2:0] atom_type = 0;
	logic [31:0] atom_mass = 0;
	logic [VW-1:0] position_xyz = 0;
	logic [VW-1:0] velocity_xyz = 0;
	logic [VW-1:0] force_xyz = 0;
	logic [VW-1:0] vest_xyz = 0;
	logic [63:0] energy_density = 0;
	logic [63:0] energy_density_rates = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [15:0] result_index;
	logic [VW-1:0] new_position_xyz;
	logic [VW-1:0] new_velocity_xyz;
	logic [VW-1:0] new_vest_xyz;
	logic [63:0] new_energy_density;
	logic overflow;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	verlet_scoreboard sb = new();
	bit no_idle = 0;
	int quiet_cycles = 0;
	logic [15:0] next_index = 0;

	sph_half_step_integrator_top dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= no_idle || ($urandom_range(99) >= 28);
		if (arst_n && out_valid && out_ready)
			sb.check_particle('{result_index, new_position_xyz, new_velocity_xyz,
				new_vest_xyz, new_energy_density, overflow});
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(logic [31:0] dtf, logic [31:0] dtv, logic [31:0] grp,
			logic im, logic [31:0] m0, logic [31:0] m1, logic [31:0] m2, logic [31:0] m3);
		write_reg(sph_pkg::REG_DTF, dtf);
		write_reg(sph_pkg::REG_DTV, dtv);
		write_reg(sph_pkg::REG_GROUP, grp);
		write_reg(sph_pkg::REG_ITEM_MASS, {31'd0, im});
		write_reg(sph_pkg::REG_MASS_ONE, m0);
		write_reg(sph_pkg::REG_MASS_ONE + 3'd1, m1);
		write_reg(sph_pkg::REG_MASS_ONE + 3'd2, m2);
		write_reg(sph_pkg::REG_MASS_ONE + 3'd3, m3);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic send_particle(particle_t it);
		while (!no_idle && $urandom_range(99) < 28) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		action <= it.action;
		particle_index <= it.index;
		group_mask <= it.mask;
		atom_type <= it.atype;
		atom_mass <= it.mass;
		position_xyz <= it.pos;
		velocity_xyz <= it.vel;
		force_xyz <= it.frc;
		vest_xyz <= it.vest;
		energy_density <= it.ed;
		energy_density_rates <= it.rates;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_particle(it);
	endtask

	function automatic logic [VW-1:0] pick_vec();
		logic [VW-1:0] r;
		int s;
		if ($urandom_range(3) == 0)
			return VW'({$urandom, $urandom});
		s = $urandom_range(14, 4);
		for (int k = 0; k < 3; k++)
			r[k*CB +: CB] = CB'($signed($urandom_range((1 << s) - 1)) - (1 << (s - 1)));
		return r;
	endfunction

	function automatic logic [31:0] pick_scalar();
		if ($urandom_range(3) == 0)
			return $urandom;
		return 32'($signed($urandom_range(32'h3FFFFF)) - 32'h200000);
	endfunction

	function automatic particle_t rand_particle();
		particle_t it;
		it.action = 2'($urandom_range(3));
		it.index = next_index;
		next_index++;
		it.mask = $urandom;
		if ($urandom_range(3) != 0)
			it.mask = it.mask | sb.group;
		it.atype = ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
		it.mass = ($urandom_range(7) == 0) ? $urandom : $urandom_range(32'h40000, 32'h800);
		if ($urandom_range(31) == 0)
			it.mass = 0;
		it.pos = pick_vec();
		it.vel = pick_vec();
		it.frc = pick_vec();
		it.vest = pick_vec();
		it.ed = {pick_scalar(), pick_scalar()};
		it.rates = {pick_scalar(), pick_scalar()};
		return it;
	endfunction

	localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

	task automatic directed();
		particle_t it;
		logic [1:0] acts[4] = '{sph_pkg::ACT_INIT, sph_pkg::ACT_FINAL,
			sph_pkg::ACT_COPY, sph_pkg::ACT_ADD};
		for (int n = 0; n < 20; n++) begin
			it = rand_particle();
			it.action = acts[n % 4];
			it.mask = (n == 16) ? ~sb.group : 32'hFFFFFFFF;
			it.atype = (n < 12) ? 3'(n % 4 + 1) : ((n == 12) ? 3'd0 : 3'd5 + 3'(n % 3));
			case (n / 4)
				0: begin
					it.pos = {CMAX, CMAX, CMAX};
					it.vel = {CMAX, CMAX, CMAX};
					it.frc = {CMAX, CMAX, CMAX};
					it.vest = {CMAX, CMAX, CMAX};
					it.ed = {32'h7FFFFFFF, 32'h7FFFFFFF};
					it.rates = {32'h7FFFFFFF, 32'h7FFFFFFF};
				end
				1: begin
					it.pos = {CMIN, CMIN, CMIN};
					it.vel = {CMIN, CMIN, CMIN};
					it.frc = {CMIN, CMIN, CMIN};
					it.vest = {CMIN, CMIN, CMIN};
					it.ed = {32'h80000000, 32'h80000000};
					it.rates = {32'h80000000, 32'h80000000};
				end
				2: begin
					it.pos = '0;
					it.vel = '0;
					it.frc = '0;
					it.vest = '0;
					it.ed = '0;
					it.rates = '0;
				end
				default: ;
			endcase
			send_particle(it);
		end
		drain();
	endtask

	task automatic random_run(int count);
		for (int n = 0; n < count; n++) begin
			no_idle = (n >= 30 && n < 70);
			if (n == 20)
				drain();
			send_particle(rand_particle());
		end
		no_idle = 0;
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed();
		configure(32'h00800000, 32'h01000000, 32'h1, 0,
			32'h10000, 32'h20000, 32'h8000, 32'h0);
		directed();
		configure(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1,
			32'hFFFFFFFF, 32'h1, 32'h0, 32'hFFFFFFFF);
		directed();
		random_run(60);
		configure(32'h0, 32'h0, 32'h80000000, 0, 32'h1, 32'hFFFFFFFF, 32'h10000, 32'h10000);
		random_run(40);
		for (int ph = 0; ph < 3; ph++) begin
			configure($urandom_range(32'h4000000), $urandom_range(32'h4000000),
				$urandom | 32'h1, ph[0], $urandom_range(32'h80000, 32'h100),
				$urandom_range(32'h80000, 32'h100), $urandom_range(32'h80000, 32'h100),
				$urandom_range(32'h80000, 32'h100));
			random_run(100);
		end
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

@@ filelist.f @@
design/sph_pkg.sv
design/sph_pipe_delay.sv
design/sph_lane.sv
design/sph_half_step_integrator_top.sv
sim/sph_half_step_integrator_top_tb.sv
